>>> hdl/igc_pkg.sv
// ----------------------------------------------------------------------------
// igc_pkg
// shared constants, coefficients and types of the inverse normal cdf core
// ----------------------------------------------------------------------------
package igc_pkg;

   localparam int PROB_WIDTH    = 32;
   localparam int OUT_FRAC_BITS = 27;
   localparam int OUT_WIDTH     = 32;
   localparam int LOG_FB        = 30;
   localparam int Q_FB          = 27;
   localparam int SQRT_STEPS    = 32;
   localparam int DIV_STEPS     = 32;

   // 2 ln 2 in q.26
   localparam logic [26:0] TWO_LN2_Q26 = 27'd93032640;

   // rational approximation coefficients, q.27
   localparam logic [29:0] C0      = 30'd337626976;
   localparam logic [29:0] C1      = 30'd107757106;
   localparam logic [29:0] C2      = 30'd1386201;
   localparam logic [29:0] D1      = 30'd192305550;
   localparam logic [29:0] D2      = 30'd25403255;
   localparam logic [29:0] D3      = 30'd175557;
   localparam logic [29:0] ONE_Q27 = 30'd134217728;

   typedef struct packed {
      logic lower;
      logic clamped;
   } side_type;

   typedef struct packed {
      logic [OUT_WIDTH-1:0] quantile;
      logic                 clamped;
   } rsp_type;

endpackage

>>> hdl/igc_if.sv
// ----------------------------------------------------------------------------
// igc_req_if / igc_rsp_if
// valid/ready channels carrying probability words in and quantile words out
// ----------------------------------------------------------------------------
interface igc_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] probability;

   modport source (output valid, output probability, input ready);
   modport sink   (input valid, input probability, output ready);
endinterface

interface igc_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] quantile;
   logic        clamped;

   modport source (output valid, output quantile, output clamped, input ready);
   modport sink   (input valid, input quantile, input clamped, output ready);
endinterface

>>> hdl/igc_log.sv
// ----------------------------------------------------------------------------
// igc_log
// tail selection, normalization and bit-per-stage log2 of the tail probability
// ----------------------------------------------------------------------------
module igc_log
   import igc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   input  logic                  in_valid,
   input  logic [PROB_WIDTH-1:0] in_prob,
   output logic                  out_valid,
   output logic [4:0]            out_e,
   output logic [LOG_FB-1:0]     out_f,
   output side_type              out_side
);

   logic [PROB_WIDTH-1:0] v_ff, v_in;
   side_type              side0_ff, side0_in;
   logic                  vld0_ff;

   logic [30:0]       m_ff    [0:LOG_FB];
   logic [LOG_FB-1:0] f_ff    [0:LOG_FB];
   logic [4:0]        e_ff    [0:LOG_FB];
   side_type          side_ff [0:LOG_FB];
   logic              vld_ff  [0:LOG_FB];

   logic [4:0]  lead;
   logic [30:0] m_norm;

   // tail select, zero clamp
   always_comb begin
      logic [PROB_WIDTH-1:0] p;
      p = in_prob;
      side0_in.clamped = (p == '0);
      if (side0_in.clamped) begin
         p = PROB_WIDTH'(1);
      end
      side0_in.lower = ~p[PROB_WIDTH-1];
      v_in = side0_in.lower ? p : (~p + PROB_WIDTH'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld0_ff <= 1'b0;
      end else if (enable) begin
         vld0_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         v_ff     <= v_in;
         side0_ff <= side0_in;
      end
   end

   // leading one and alignment to q1.30
   always_comb begin
      lead = '0;
      for (int i = 0; i < PROB_WIDTH; i++) begin
         if (v_ff[i]) begin
            lead = 5'(i);
         end
      end
      if (lead == 5'd31) begin
         m_norm = v_ff[31:1];
      end else begin
         m_norm = 31'(v_ff << (5'd30 - lead));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (enable) begin
         vld_ff[0] <= vld0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         m_ff[0]    <= m_norm;
         f_ff[0]    <= '0;
         e_ff[0]    <= lead;
         side_ff[0] <= side0_ff;
      end
   end

   // one fraction bit per stage by repeated squaring
   for (genvar g = 0; g < LOG_FB; g++) begin : g_round
      logic [61:0] sq;
      logic [31:0] sh;
      logic [30:0] m_next;
      logic        fbit;

      always_comb begin
         sq     = 62'(m_ff[g]) * 62'(m_ff[g]);
         sh     = sq[61:30];
         fbit   = sh[31];
         m_next = fbit ? sh[31:1] : sh[30:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g+1] <= 1'b0;
         end else if (enable) begin
            vld_ff[g+1] <= vld_ff[g];
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            m_ff[g+1]    <= m_next;
            f_ff[g+1]    <= {f_ff[g][LOG_FB-2:0], fbit};
            e_ff[g+1]    <= e_ff[g];
            side_ff[g+1] <= side_ff[g];
         end
      end
   end

   assign out_valid = vld_ff[LOG_FB];
   assign out_e     = e_ff[LOG_FB];
   assign out_f     = f_ff[LOG_FB];
   assign out_side  = side_ff[LOG_FB];

endmodule

>>> hdl/igc_sqrt.sv
// ----------------------------------------------------------------------------
// igc_sqrt
// scales -log2 q to -2 ln q and takes t = sqrt(-2 ln q) one root bit a stage
// ----------------------------------------------------------------------------
module igc_sqrt
   import igc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  logic              in_valid,
   input  logic [4:0]        in_e,
   input  logic [LOG_FB-1:0] in_f,
   input  side_type          in_side,
   output logic              out_valid,
   output logic [30:0]       out_t,
   output side_type          out_side
);

   logic [35:0] u_ff, u_in;
   side_type    side_u_ff;
   logic        vld_u_ff;
   logic [62:0] prod;

   logic [63:0] rem_ff  [0:SQRT_STEPS];
   logic [63:0] res_ff  [0:SQRT_STEPS];
   side_type    side_ff [0:SQRT_STEPS];
   logic        vld_ff  [0:SQRT_STEPS];

   assign u_in = (36'(PROB_WIDTH) << LOG_FB) - ((36'(in_e) << LOG_FB) + 36'(in_f));
   assign prod = 63'(u_ff) * 63'(TWO_LN2_Q26);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_u_ff  <= 1'b0;
         vld_ff[0] <= 1'b0;
      end else if (enable) begin
         vld_u_ff  <= in_valid;
         vld_ff[0] <= vld_u_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         u_ff       <= u_in;
         side_u_ff  <= in_side;
         rem_ff[0]  <= {3'b000, prod[62:26], 24'd0};
         res_ff[0]  <= '0;
         side_ff[0] <= side_u_ff;
      end
   end

   for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_root
      localparam logic [63:0] Bit = 64'd1 << (62 - 2 * g);
      logic [63:0] trial;
      logic        take;

      assign trial = res_ff[g] + Bit;
      assign take  = rem_ff[g] >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g+1] <= 1'b0;
         end else if (enable) begin
            vld_ff[g+1] <= vld_ff[g];
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[g+1]  <= take ? (rem_ff[g] - trial) : rem_ff[g];
            res_ff[g+1]  <= take ? ((res_ff[g] >> 1) + Bit) : (res_ff[g] >> 1);
            side_ff[g+1] <= side_ff[g];
         end
      end
   end

   assign out_valid = vld_ff[SQRT_STEPS];
   assign out_t     = res_ff[SQRT_STEPS][30:0];
   assign out_side  = side_ff[SQRT_STEPS];

endmodule

>>> hdl/igc_rat.sv
// ----------------------------------------------------------------------------
// igc_rat
// rational correction by horner stages, restoring divide, sign and rescale
// ----------------------------------------------------------------------------
module igc_rat
   import igc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        enable,
   input  logic        in_valid,
   input  logic [30:0] in_t,
   input  side_type    in_side,
   output logic        out_valid,
   output rsp_type     out_rsp
);

   localparam int UpShift = (OUT_FRAC_BITS >= Q_FB) ? (OUT_FRAC_BITS - Q_FB) : 0;
   localparam int DnShift = (OUT_FRAC_BITS < Q_FB) ? (Q_FB - OUT_FRAC_BITS) : 0;
   localparam logic [63:0] RoundBit = (DnShift > 0) ? (64'd1 << ((DnShift > 0) ? DnShift - 1 : 0))
                                                    : 64'd0;

   // horner stage 1
   logic [27:0] n1_ff;
   logic [25:0] d1_ff;
   logic [30:0] t1_ff;
   side_type    side1_ff;
   logic        vld1_ff;
   // horner stage 2
   logic [32:0] n2_ff;
   logic [30:0] d2_ff;
   logic [30:0] t2_ff;
   side_type    side2_ff;
   logic        vld2_ff;

   logic [51:0] pn1;
   logic [48:0] pd1;
   logic [58:0] pn2;
   logic [56:0] pd2;
   logic [61:0] pd3;

   // divider stages, index 0 is the last horner stage
   logic [36:0] rem_ff  [0:DIV_STEPS];
   logic [31:0] q_ff    [0:DIV_STEPS];
   logic [32:0] n_ff    [0:DIV_STEPS];
   logic [35:0] den_ff  [0:DIV_STEPS];
   logic [30:0] t_ff    [0:DIV_STEPS];
   side_type    side_ff [0:DIV_STEPS];
   logic        vld_ff  [0:DIV_STEPS];

   rsp_type rsp_ff, rsp_in;
   logic    vldo_ff;

   assign pn1 = 52'(C2[20:0]) * 52'(in_t);
   assign pd1 = 49'(D3[17:0]) * 49'(in_t);
   assign pn2 = 59'(n1_ff) * 59'(t1_ff);
   assign pd2 = 57'(d1_ff) * 57'(t1_ff);
   assign pd3 = 62'(d2_ff) * 62'(t2_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff   <= 1'b0;
         vld2_ff   <= 1'b0;
         vld_ff[0] <= 1'b0;
      end else if (enable) begin
         vld1_ff   <= in_valid;
         vld2_ff   <= vld1_ff;
         vld_ff[0] <= vld2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         n1_ff      <= 28'(pn1 >> Q_FB) + 28'(C1);
         d1_ff      <= 26'(pd1 >> Q_FB) + 26'(D2);
         t1_ff      <= in_t;
         side1_ff   <= in_side;
         n2_ff      <= 33'(pn2 >> Q_FB) + 33'(C0);
         d2_ff      <= 31'(pd2 >> Q_FB) + 31'(D1);
         t2_ff      <= t1_ff;
         side2_ff   <= side1_ff;
         rem_ff[0]  <= 37'(n2_ff >> (32 - Q_FB));
         q_ff[0]    <= '0;
         n_ff[0]    <= n2_ff;
         den_ff[0]  <= 36'(pd3 >> Q_FB) + 36'(ONE_Q27);
         t_ff[0]    <= t2_ff;
         side_ff[0] <= side2_ff;
      end
   end

   // one quotient bit per stage of (num << 27) / den
   for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
      localparam int Pos = DIV_STEPS - 1 - g;
      logic        nbit;
      logic [36:0] rem2;
      logic        take;

      if (Pos >= Q_FB) begin : g_nb
         assign nbit = n_ff[g][Pos - Q_FB];
      end else begin : g_zb
         assign nbit = 1'b0;
      end

      assign rem2 = {rem_ff[g][35:0], nbit};
      assign take = rem2 >= {1'b0, den_ff[g]};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g+1] <= 1'b0;
         end else if (enable) begin
            vld_ff[g+1] <= vld_ff[g];
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[g+1]  <= take ? (rem2 - {1'b0, den_ff[g]}) : rem2;
            q_ff[g+1]    <= {q_ff[g][30:0], take};
            n_ff[g+1]    <= n_ff[g];
            den_ff[g+1]  <= den_ff[g];
            t_ff[g+1]    <= t_ff[g];
            side_ff[g+1] <= side_ff[g];
         end
      end
   end

   // x = t - r, sign, rescale, saturate
   always_comb begin
      logic signed [33:0] x;
      logic               neg;
      logic [63:0]        mag;
      x = $signed({3'b000, t_ff[DIV_STEPS]}) - $signed({2'b00, q_ff[DIV_STEPS]});
      if (side_ff[DIV_STEPS].lower) begin
         x = -x;
      end
      neg = x[33];
      mag = neg ? 64'(-x) : 64'(x);
      if (DnShift == 0) begin
         mag = mag << UpShift;
      end else begin
         mag = (mag + RoundBit) >> DnShift;
      end
      if (neg) begin
         if (mag > 64'h8000_0000) begin
            mag = 64'h8000_0000;
         end
         rsp_in.quantile = ~mag[31:0] + 32'd1;
      end else begin
         if (mag > 64'h7FFF_FFFF) begin
            mag = 64'h7FFF_FFFF;
         end
         rsp_in.quantile = mag[31:0];
      end
      rsp_in.clamped = side_ff[DIV_STEPS].clamped;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vldo_ff <= 1'b0;
      end else if (enable) begin
         vldo_ff <= vld_ff[DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = vldo_ff;
   assign out_rsp   = rsp_ff;

endmodule

>>> hdl/inverse_gaussian_cdf_core.sv
// ----------------------------------------------------------------------------
// inverse_gaussian_cdf_core
// fixed-point inverse standard normal cdf, when unstalled one word per clock
// ----------------------------------------------------------------------------
// req_if carries a probability word p (unsigned 0.32); rsp_if returns the
// normal quantile (signed, 27 fraction bits) and a clamped flag that marks a
// zero input raised to the smallest probability 2^-32.
// throughput: one word per clock, sustained, whenever rsp_if.ready stays high
// path: from acceptance to rsp_if.valid a word passes the 30 squaring
// stages of the log2, the 32 root stages and the 32 divide stages, each of
// which produces one result bit per register stage
// stall: the whole pipe advances on one enable; a word leaving the pipe while
// the output register is held goes to a skid register, and a full skid
// register drops req_if.ready and freezes the pipe, so nothing is lost
// reset: synchronous, clears every valid bit, also those of the output and skid registers;
// no table or memory needs clearing, the block takes words right after reset
// ----------------------------------------------------------------------------
module inverse_gaussian_cdf_core
   import igc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   igc_req_if.sink   req_if,
   igc_rsp_if.source rsp_if
);

   logic              pipe_enable;
   logic              log_valid;
   logic [4:0]        log_e;
   logic [LOG_FB-1:0] log_f;
   side_type          log_side;
   logic              sqrt_valid;
   logic [30:0]       sqrt_t;
   side_type          sqrt_side;
   logic              rat_valid;
   rsp_type           rat_rsp;

   // output register and skid register
   logic    out_valid_ff, out_valid_in;
   rsp_type out_ff, out_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type skid_ff, skid_in;
   logic    rsp_fire;

   // skid full freezes the pipe; ready comes straight from a flop
   assign pipe_enable  = ~skid_valid_ff;
   assign req_if.ready = pipe_enable;

   igc_log u_log (
      .clock     (clock),
      .reset     (reset),
      .enable    (pipe_enable),
      .in_valid  (req_if.valid),
      .in_prob   (req_if.probability),
      .out_valid (log_valid),
      .out_e     (log_e),
      .out_f     (log_f),
      .out_side  (log_side)
   );

   igc_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .enable    (pipe_enable),
      .in_valid  (log_valid),
      .in_e      (log_e),
      .in_f      (log_f),
      .in_side   (log_side),
      .out_valid (sqrt_valid),
      .out_t     (sqrt_t),
      .out_side  (sqrt_side)
   );

   igc_rat u_rat (
      .clock     (clock),
      .reset     (reset),
      .enable    (pipe_enable),
      .in_valid  (sqrt_valid),
      .in_t      (sqrt_t),
      .in_side   (sqrt_side),
      .out_valid (rat_valid),
      .out_rsp   (rat_rsp)
   );

   assign rsp_fire = out_valid_ff & rsp_if.ready;

   // a pipe word is taken whenever the pipe advances; it lands in the output
   // register if that frees up this cycle, otherwise in the skid register
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (rsp_fire) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else begin
         if (~out_valid_ff | rsp_fire) begin
            out_valid_in = rat_valid;
            out_in       = rat_rsp;
         end else if (rat_valid) begin
            skid_valid_in = 1'b1;
            skid_in       = rat_rsp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_if.valid    = out_valid_ff;
   assign rsp_if.quantile = out_ff.quantile;
   assign rsp_if.clamped  = out_ff.clamped;

endmodule

>>> hdl/igc_checker.sv
// ----------------------------------------------------------------------------
// igc_checker
// port-level checks of the inverse normal cdf core, bound to the top level
// ----------------------------------------------------------------------------
module igc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_quantile,
   input logic        rsp_clamped
);

   // a held word stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp word dropped while stalled");

   // a held word keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_quantile) && $stable(rsp_clamped))
      else $error("rsp word changed while stalled");

   // a clamped zero input is the far lower tail
   a_clamp_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_clamped |-> rsp_quantile[31])
      else $error("clamped word with non-negative quantile");

   // input back-pressure only follows an output stall
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && $past(rsp_valid && !rsp_ready))
      else $error("req ready low without an output stall");

   // an offered word is only stalled while an output word is pending or rsp ready is low
   a_no_accept_frozen: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |-> !rsp_ready || rsp_valid)
      else $error("input stalled without a pending output word");

endmodule

bind inverse_gaussian_cdf_core igc_checker u_igc_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_if.valid),
   .req_ready    (req_if.ready),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .rsp_quantile (rsp_if.quantile),
   .rsp_clamped  (rsp_if.clamped)
);

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the inverse normal cdf core: probability words go
// in through a bursty sender, quantile words come back through a stalling
// receiver, and each one is checked against a bit-exact integer predictor
// ----------------------------------------------------------------------------
module tb_top;
   import igc_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;

   igc_req_if req_ch ();
   igc_rsp_if rsp_ch ();

   inverse_gaussian_cdf_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   always #5 clock = ~clock;

   // quantiles still owed by the core, oldest first
   rsp_type pending_quantiles[$];

   int error_count    = 0;
   int words_sent     = 0;
   int words_checked  = 0;
   int clamped_seen   = 0;
   int hold_cycles    = 0;   // long receiver hold-off, counted down below
   int stall_mode     = 0;   // selects the receiver's stall pattern

   // ------------------------------------------------------------------------
   // predictor: tail quantile by log2 squaring, root, rational fit
   // ------------------------------------------------------------------------
   function automatic rsp_type predict_quantile(logic [31:0] prob);
      rsp_type     res;
      logic [63:0] p, v, m, f, u, s, rem, root, bitv, mag;
      longint      t, num, den, r, x;
      int          e;
      logic        lower, clamp, neg;
      p     = 64'(prob);
      clamp = 1'b0;
      lower = 1'b0;
      e     = 0;
      f     = 0;
      // zero is raised to the smallest probability
      if (p == 0) begin
         p     = 1;
         clamp = 1'b1;
      end
      // exactly one half takes the upper branch
      if (p < (64'd1 << (PROB_WIDTH - 1))) begin
         v     = p;
         lower = 1'b1;
      end else begin
         v = ((64'd1 << PROB_WIDTH) - 1 - p) + 1;
      end
      for (int i = 0; i < 64; i++)
         if (v[i]) e = i;
      m = (e > LOG_FB) ? (v >> (e - LOG_FB)) : (v << (LOG_FB - e));
      // log2 fraction, one bit per squaring
      for (int i = 0; i < LOG_FB; i++) begin
         m = (m * m) >> LOG_FB;
         f = f << 1;
         if (m >= (64'd2 << LOG_FB)) begin
            f[0] = 1'b1;
            m    = m >> 1;
         end
      end
      u = (64'(PROB_WIDTH) << LOG_FB) - ((64'(e) << LOG_FB) + f);
      s = (u * 64'(TWO_LN2_Q26)) >> 26;
      // floor square root, two bits per round
      rem  = s << 24;
      root = 0;
      bitv = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (rem >= root + bitv) begin
            rem  = rem - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      t   = longint'(root);
      num = ((longint'(C2) * t) >>> Q_FB) + longint'(C1);
      num = ((num * t) >>> Q_FB) + longint'(C0);
      den = ((longint'(D3) * t) >>> Q_FB) + longint'(D2);
      den = ((den * t) >>> Q_FB) + longint'(D1);
      den = ((den * t) >>> Q_FB) + longint'(ONE_Q27);
      r   = longint'((64'(num) << Q_FB) / 64'(den));
      x   = t - r;
      if (lower) x = -x;
      neg = (x < 0);
      mag = neg ? 64'(-x) : 64'(x);
      if (OUT_FRAC_BITS >= Q_FB)
         mag = mag << (OUT_FRAC_BITS - Q_FB);
      else
         mag = (mag + (64'd1 << (Q_FB - OUT_FRAC_BITS - 1))) >> (Q_FB - OUT_FRAC_BITS);
      // saturate to the signed output range
      if (neg) begin
         if (mag > 64'h8000_0000) mag = 64'h8000_0000;
         mag = -mag;
      end else if (mag > 64'h7FFF_FFFF) begin
         mag = 64'h7FFF_FFFF;
      end
      res.quantile = mag[OUT_WIDTH-1:0];
      res.clamped  = clamp;
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // sender: one word, held until accepted; valid stays high into the next
   // word of a burst and is only lowered by idle_sender
   // ------------------------------------------------------------------------
   task automatic send_probability(logic [31:0] prob);
      @(negedge clock);
      req_ch.valid       = 1'b1;
      req_ch.probability = prob;
      do @(posedge clock); while (!req_ch.ready);
      pending_quantiles = {pending_quantiles, predict_quantile(prob)};
      words_sent++;
   endtask

   task automatic idle_sender(int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_ch.valid       = 1'b0;
         req_ch.probability = $urandom;
      end
   endtask

   // bursts of random length with random gaps; about a quarter of bursts
   // run back to back
   int burst_left = 0;
   task automatic send_with_gaps(logic [31:0] prob);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 9));
      end
      burst_left--;
      send_probability(prob);
   endtask

   // random probability with weight on the tails, the midpoint and the ends
   function automatic logic [31:0] pick_probability();
      logic [31:0] p;
      case ($urandom_range(0, 9))
         0:       p = $urandom >> $urandom_range(0, 31);                 // deep lower tail
         1:       p = ~($urandom >> $urandom_range(0, 31));              // deep upper tail
         2:       p = 32'h8000_0000 + $urandom_range(0, 64) - 32;         // around one half
         3:       p = $urandom_range(0, 3);                              // zero and tiny
         4:       p = 32'hFFFF_FFFF - $urandom_range(0, 3);              // top end
         default: p = $urandom;
      endcase
      return p;
   endfunction

   // ------------------------------------------------------------------------
   // receiver: stall pattern that changes character over the run, plus a
   // long hold-off on demand
   // ------------------------------------------------------------------------
   int stall_phase = 0;
   always @(negedge clock) begin
      stall_phase <= stall_phase + 1;
      if (hold_cycles > 0) begin
         hold_cycles   <= hold_cycles - 1;
         rsp_ch.ready  <= 1'b0;
      end else begin
         case (stall_mode)
            0:       rsp_ch.ready <= 1'b1;                               // no stalls
            1:       rsp_ch.ready <= ($urandom_range(0, 3) != 0);          // light
            2:       rsp_ch.ready <= ($urandom_range(0, 1) != 0);          // heavy
            default: rsp_ch.ready <= ((stall_phase % 7) < 4);              // periodic
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // checker: each accepted quantile against the oldest prediction
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_quantiles.size() == 0) begin
            $error("unexpected quantile word %h clamped %b", rsp_ch.quantile, rsp_ch.clamped);
            error_count++;
         end else begin
            want = pending_quantiles.pop_front();
            if (rsp_ch.quantile !== want.quantile) begin
               $error("quantile: expected %h actual %h", want.quantile, rsp_ch.quantile);
               error_count++;
            end
            if (rsp_ch.clamped !== want.clamped) begin
               $error("clamped: expected %b actual %b", want.clamped, rsp_ch.clamped);
               error_count++;
            end
            if (want.clamped) clamped_seen++;
            words_checked++;
         end
      end
   end

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   // ends, midpoint, zero clamp, walking ones in steps of four bits
   task automatic test_directed();
      logic [31:0] edges[$] = '{32'h0000_0000, 32'h0000_0001, 32'h0000_0002,
                                32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
                                32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h4000_0000,
                                32'hC000_0000, 32'h5555_5555, 32'hAAAA_AAAA,
                                32'h0000_FFFF, 32'hFFFF_0000, 32'h0010_0000,
                                32'hFFF0_0000};
      stall_mode = 0;
      foreach (edges[i]) send_probability(edges[i]);
      for (int b = 0; b < 32; b += 4) send_probability(32'h1 << b);
   endtask

   // bulk random words under changing stall patterns
   task automatic test_random(int count);
      for (int i = 0; i < count; i++) begin
         if (i % 150 == 0) stall_mode = $urandom_range(0, 3);
         send_with_gaps(pick_probability());
      end
   endtask

   // long hold-off so the pipe and skid fill and input ready drops
   task automatic test_backpressure();
      stall_mode = 0;
      idle_sender(1);
      hold_cycles = 400;
      for (int i = 0; i < 160; i++) send_probability(pick_probability());
   endtask

   // sender pauses until the core has returned everything
   task automatic test_drain_pause();
      idle_sender(1);
      wait (pending_quantiles.size() == 0);
      for (int i = 0; i < 20; i++) send_probability(pick_probability());
   endtask

   initial begin
      req_ch.valid       = 1'b0;
      req_ch.probability = '0;
      rsp_ch.ready       = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_random(450);
      test_backpressure();
      test_drain_pause();
      test_random(500);

      idle_sender(1);
      stall_mode = 1;
      wait (pending_quantiles.size() == 0);
      repeat (120) @(posedge clock);

      $display("sent %0d probability words, checked %0d quantiles (%0d clamped zeros)",
               words_sent, words_checked, clamped_seen);
      $display("covered tails, midpoint, ends, bursty input, stalls and a full-pipe hold-off");
      if (error_count == 0 && pending_quantiles.size() == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

   // run limit, far beyond the slowest legal run
   initial begin
      #3000000;
      $display("tb_top: errors");
      $finish;
   end

endmodule

>>> inverse_gaussian_cdf_core.f
hdl/igc_pkg.sv
hdl/igc_if.sv
hdl/igc_log.sv
hdl/igc_sqrt.sv
hdl/igc_rat.sv
hdl/inverse_gaussian_cdf_core.sv
hdl/igc_checker.sv
tb/sv/tb_top.sv
